/* hw/rtl/sllsc_pkg.sv */
// Package for the shared memory with load-linked / store-conditional reservations.
// Holds field widths, access kind and status codes, and the reservation request type.
// No dependencies; used by sllsc_resv, the top module and the testbench.
package sllsc_pkg;

    // Default sizes
    localparam int MEM_BYTES_DEF = 65536;
    localparam int MAX_PROCS_DEF = 8;

    // Field widths
    localparam int KIND_W = 3;
    localparam int PID_W  = 4;
    localparam int DATA_W = 32;
    localparam int ST_W   = 3;
    localparam int NP_W   = 4;
    localparam int CNT_W  = 5;   // holds a processor count up to 16

    // Stream widths (padded to whole bytes)
    localparam int S_TDATA_W = 72;  // proc_id, address, store_data
    localparam int M_TDATA_W = 40;  // read_data, status

    // Access kinds
    localparam logic [KIND_W-1:0] K_LW = 3'd0;
    localparam logic [KIND_W-1:0] K_SW = 3'd1;
    localparam logic [KIND_W-1:0] K_LL = 3'd2;
    localparam logic [KIND_W-1:0] K_SC = 3'd3;
    localparam logic [KIND_W-1:0] K_LB = 3'd4;
    localparam logic [KIND_W-1:0] K_SB = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_RANGE  = 3'd1;
    localparam logic [ST_W-1:0] ST_ALIGN  = 3'd2;
    localparam logic [ST_W-1:0] ST_PROC   = 3'd3;
    localparam logic [ST_W-1:0] ST_SCFAIL = 3'd4;

    // Reservation table operations
    localparam logic RV_LINK  = 1'b0;
    localparam logic RV_CLEAR = 1'b1;

    typedef struct packed {
        logic              en;
        logic              op;
        logic [PID_W-1:0]  pid;
        logic [DATA_W-1:0] addr;
        logic [CNT_W-1:0]  active;
    } t_resv_req;

endpackage

/* hw/rtl/sllsc_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module sllsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* hw/rtl/sllsc_resv.sv */
// Reservation table: one address and valid bit per processor, compared in parallel.
// Depends on sllsc_pkg for the request type and operation codes.
module sllsc_resv #(
    parameter int MAX_PROCS = sllsc_pkg::MAX_PROCS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sllsc_pkg::t_resv_req  i_req,
    output logic                  o_own_match
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

    logic [MAX_PROCS-1:0]          r_valid;
    logic [MAX_PROCS-1:0]          n_valid;
    logic [sllsc_pkg::DATA_W-1:0]  r_addr [MAX_PROCS];
    logic [IDX_W-1:0]              own_idx;

    // Only meaningful while pid is below the active count
    assign own_idx     = i_req.pid[IDX_W-1:0];
    assign o_own_match = r_valid[own_idx] && (r_addr[own_idx] == i_req.addr);

    // Next valid bits: set on link, clear matching active entries on clear
    always_comb begin
        n_valid = r_valid;
        if (i_req.en) begin
            if (i_req.op == sllsc_pkg::RV_LINK) begin
                n_valid[own_idx] = 1'b1;
            end else begin
                for (int i = 0; i < MAX_PROCS; i++) begin
                    if ((sllsc_pkg::CNT_W'(i) < i_req.active) &&
                        (r_addr[i] == i_req.addr)) begin
                        n_valid[i] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Reserved addresses are only looked at while valid
    always_ff @(posedge i_clk) begin
        if (i_req.en && (i_req.op == sllsc_pkg::RV_LINK)) begin
            r_addr[own_idx] <= i_req.addr;
        end
    end

endmodule

/* hw/rtl/shared_memory_with_ll_sc_top.sv */
// Shared word memory with load-linked / store-conditional reservations.
// A request is registered on acceptance, with its word RAM read, and its result is registered
// when the execute state fires; execute waits while a held result is not yet taken.
// A new request is taken only after the previous one has left execute (word RAM read, then
// its modify/write-back). Reset (synchronous, active low) starts a clearing pass over the
// MEM_BYTES/4 words (16384 by default) that zeroes the RAM; no item is taken until it ends.
module shared_memory_with_ll_sc_top #(
    parameter int MEM_BYTES = sllsc_pkg::MEM_BYTES_DEF,
    parameter int MAX_PROCS = sllsc_pkg::MAX_PROCS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: num_procs
    input  logic                            i_cfg_we,
    input  logic [sllsc_pkg::NP_W-1:0]      i_cfg_wdata,
    // requests
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [3:0] proc_id, [35:4] address, [67:36] store_data, [71:68] zero
    input  logic [sllsc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [2:0] kind
    input  logic [sllsc_pkg::KIND_W-1:0]    s_axis_tuser,
    // results
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] read_data, [34:32] status, [39:35] zero
    output logic [sllsc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int WORD_COUNT = (MEM_BYTES + 3) / 4;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int DW         = sllsc_pkg::DATA_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                           r_state;
    logic                           r_clr_busy;
    logic [ADDR_W-1:0]              r_clr_idx;
    logic [sllsc_pkg::NP_W-1:0]     r_num_procs;
    logic [sllsc_pkg::KIND_W-1:0]   r_kind;
    logic [sllsc_pkg::PID_W-1:0]    r_pid;
    logic [DW-1:0]                  r_addr;
    logic [DW-1:0]                  r_data;
    logic                           r_out_valid;
    logic [DW-1:0]                  r_out_rd;
    logic [sllsc_pkg::ST_W-1:0]     r_out_st;

    logic                           in_fire;
    logic                           exec_fire;
    logic [DW-1:0]                  ram_rdata;
    logic                           ram_we;
    logic [ADDR_W-1:0]              ram_waddr;
    logic [DW-1:0]                  ram_wdata;
    logic [ADDR_W-1:0]              in_widx;
    logic [sllsc_pkg::CNT_W-1:0]    active;
    logic                           shared;
    logic                           pid_err;
    logic                           range_err;
    logic                           align_err;
    logic [sllsc_pkg::ST_W-1:0]     word_st;
    logic                           own_match;
    logic [7:0]                     rd_byte;
    logic [DW-1:0]                  merged;
    logic [DW-1:0]                  n_rd;
    logic [sllsc_pkg::ST_W-1:0]     n_st;
    logic                           mem_wr;
    logic [DW-1:0]                  mem_wdata;
    sllsc_pkg::t_resv_req           resv_req;

    // Handshakes
    assign s_axis_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign exec_fire     = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_st, r_out_rd};

    // Processor count and sharing
    assign active  = ({1'b0, r_num_procs} > sllsc_pkg::CNT_W'(MAX_PROCS))
                   ? sllsc_pkg::CNT_W'(MAX_PROCS) : {1'b0, r_num_procs};
    assign shared  = r_num_procs > sllsc_pkg::NP_W'(1);
    assign pid_err = {1'b0, r_pid} >= active;

    // Address checks
    assign range_err = r_addr >= 32'(MEM_BYTES);
    assign align_err = r_addr[1:0] != 2'b00;
    assign word_st   = range_err ? sllsc_pkg::ST_RANGE
                     : (align_err ? sllsc_pkg::ST_ALIGN : sllsc_pkg::ST_OK);

    // Byte lane select and merge, little-endian
    always_comb begin
        rd_byte = ram_rdata[7:0];
        merged  = ram_rdata;
        for (int b = 0; b < 4; b++) begin
            if (r_addr[1:0] == 2'(b)) begin
                rd_byte         = ram_rdata[8*b +: 8];
                merged[8*b +: 8] = r_data[7:0];
            end
        end
    end

    // Execute: result, memory write-back and reservation update
    always_comb begin
        n_rd            = '0;
        n_st            = sllsc_pkg::ST_OK;
        mem_wr          = 1'b0;
        mem_wdata       = r_data;
        resv_req.en     = 1'b0;
        resv_req.op     = sllsc_pkg::RV_LINK;
        resv_req.pid    = r_pid;
        resv_req.addr   = r_addr;
        resv_req.active = active;
        unique case (r_kind)
            sllsc_pkg::K_LW, sllsc_pkg::K_LL: begin
                if ((r_kind == sllsc_pkg::K_LL) && shared && pid_err) begin
                    n_st = sllsc_pkg::ST_PROC;
                end else begin
                    if ((r_kind == sllsc_pkg::K_LL) && shared) begin
                        resv_req.en = 1'b1;
                        resv_req.op = sllsc_pkg::RV_LINK;
                    end
                    n_st = word_st;
                    if (word_st == sllsc_pkg::ST_OK) begin
                        n_rd = ram_rdata;
                    end
                end
            end
            sllsc_pkg::K_SW, sllsc_pkg::K_SC: begin
                if ((r_kind == sllsc_pkg::K_SC) && shared && pid_err) begin
                    n_st = sllsc_pkg::ST_PROC;
                end else if ((r_kind == sllsc_pkg::K_SC) && shared && !own_match) begin
                    n_st = sllsc_pkg::ST_SCFAIL;
                end else begin
                    if (shared) begin
                        resv_req.en = 1'b1;
                        resv_req.op = sllsc_pkg::RV_CLEAR;
                    end
                    n_st   = word_st;
                    mem_wr = word_st == sllsc_pkg::ST_OK;
                end
            end
            sllsc_pkg::K_LB: begin
                if (range_err) begin
                    n_st = sllsc_pkg::ST_RANGE;
                end else begin
                    n_rd = {24'd0, rd_byte};
                end
            end
            sllsc_pkg::K_SB: begin
                if (range_err) begin
                    n_st = sllsc_pkg::ST_RANGE;
                end else begin
                    mem_wr    = 1'b1;
                    mem_wdata = merged;
                end
            end
            default: begin
            end
        endcase
        resv_req.en = resv_req.en && exec_fire;
    end

    // RAM port muxing: clearing pass owns the write port after reset
    assign in_widx   = s_axis_tdata[4 + 2 +: ADDR_W];
    assign ram_we    = r_clr_busy || (exec_fire && mem_wr);
    assign ram_waddr = r_clr_busy ? r_clr_idx : r_addr[2 +: ADDR_W];
    assign ram_wdata = r_clr_busy ? '0 : mem_wdata;

    sllsc_ram #(
        .WIDTH (DW),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_fire),
        .i_raddr (in_widx),
        .o_rdata (ram_rdata)
    );

    sllsc_resv #(
        .MAX_PROCS (MAX_PROCS)
    ) u_resv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (resv_req),
        .o_own_match (own_match)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_num_procs <= sllsc_pkg::NP_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_procs <= i_cfg_wdata;
            end
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + ADDR_W'(1);
                if (r_clr_idx == ADDR_W'(WORD_COUNT - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind <= s_axis_tuser;
            r_pid  <= s_axis_tdata[3:0];
            r_addr <= s_axis_tdata[35:4];
            r_data <= s_axis_tdata[67:36];
        end
        if (exec_fire) begin
            r_out_rd <= n_rd;
            r_out_st <= n_st;
        end
    end

    // Checks
    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) r_clr_busy |-> !s_axis_tready
    ) else $error("request taken during RAM clearing pass");

    a_accept_goes_exec: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_EXEC)
    ) else $error("accepted request did not enter execute");

    a_result_from_exec: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_EXEC)
    ) else $error("result appeared without an execute cycle");

endmodule

/* verif/tb_shared_memory_with_ll_sc_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for shared_memory_with_ll_sc_top: directed table then random phases.
// Depends on sllsc_pkg and the RTL; an internal predictor tracks memory and reservations.
module tb_shared_memory_with_ll_sc_top;

    localparam int MEM_SIZE = sllsc_pkg::MEM_BYTES_DEF;
    localparam int MAXP     = sllsc_pkg::MAX_PROCS_DEF;
    localparam int WORDS    = MEM_SIZE / 4;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 180;

    // kinds the block ignores
    localparam logic [sllsc_pkg::KIND_W-1:0] K_UNUSED_A = 3'd6;
    localparam logic [sllsc_pkg::KIND_W-1:0] K_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [sllsc_pkg::DATA_W-1:0] rd;
        logic [sllsc_pkg::ST_W-1:0]   st;
        logic [sllsc_pkg::KIND_W-1:0] kind;
        logic [sllsc_pkg::DATA_W-1:0] addr;
    } t_reply;

    // directed row: either a num_procs write or one access, optionally with typed result
    typedef struct packed {
        bit                           cfg;
        logic [sllsc_pkg::NP_W-1:0]   np;
        logic [sllsc_pkg::KIND_W-1:0] kind;
        logic [sllsc_pkg::PID_W-1:0]  pid;
        logic [sllsc_pkg::DATA_W-1:0] addr;
        logic [sllsc_pkg::DATA_W-1:0] data;
        bit                           typed;
        logic [sllsc_pkg::DATA_W-1:0] rd;
        logic [sllsc_pkg::ST_W-1:0]   st;
    } t_row;

    localparam int N_ROWS = 31;
    t_row script [N_ROWS] = '{
        '{0, 0, sllsc_pkg::K_LW, 4'd0, 32'h0, 32'h0, 1, 32'h0, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_SW, 4'd0, 32'h0000_FFFC, 32'hFFFF_FFFF, 1, 32'h0, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_LW, 4'd0, 32'h0000_FFFC, 32'h0, 1, 32'hFFFF_FFFF, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_LW, 4'd0, 32'h0001_0000, 32'h0, 1, 32'h0, sllsc_pkg::ST_RANGE},
        '{0, 0, sllsc_pkg::K_SW, 4'd0, 32'hFFFF_FFFF, 32'h0, 1, 32'h0, sllsc_pkg::ST_RANGE},
        '{0, 0, sllsc_pkg::K_LW, 4'd0, 32'h0000_0002, 32'h0, 1, 32'h0, sllsc_pkg::ST_ALIGN},
        '{0, 0, sllsc_pkg::K_SB, 4'd0, 32'h0000_0003, 32'h1234_56A5, 1, 32'h0, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_LB, 4'd0, 32'h0000_0003, 32'h0, 1, 32'h0000_00A5, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_LB, 4'd0, 32'h0000_FFFF, 32'h0, 1, 32'h0000_00FF, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_SB, 4'd0, 32'hFFFF_FFFF, 32'h0000_00FF, 1, 32'h0, sllsc_pkg::ST_RANGE},
        '{0, 0, sllsc_pkg::K_LL, 4'd15, 32'h0, 32'h0, 1, 32'hA500_0000, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_SC, 4'd15, 32'h0000_0004, 32'h1234_5678, 1, 32'h0, sllsc_pkg::ST_OK},
        '{0, 0, K_UNUSED_A, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, sllsc_pkg::ST_OK},
        '{1, 4'd8, sllsc_pkg::K_LW, 4'd0, 32'h0, 32'h0, 0, 32'h0, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_LL, 4'd8, 32'h0000_0004, 32'h0, 1, 32'h0, sllsc_pkg::ST_PROC},
        '{0, 0, sllsc_pkg::K_LL, 4'd0, 32'h0000_0004, 32'h0, 1, 32'h1234_5678, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_LL, 4'd1, 32'h0000_0004, 32'h0, 0, 32'h0, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_SC, 4'd2, 32'h0000_0004, 32'h0, 1, 32'h0, sllsc_pkg::ST_SCFAIL},
        '{0, 0, sllsc_pkg::K_SC, 4'd0, 32'h0000_0004, 32'hDEAD_BEEF, 1, 32'h0, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_SC, 4'd1, 32'h0000_0004, 32'h0, 1, 32'h0, sllsc_pkg::ST_SCFAIL},
        '{0, 0, sllsc_pkg::K_LL, 4'd7, 32'h0001_0002, 32'h0, 1, 32'h0, sllsc_pkg::ST_RANGE},
        '{0, 0, sllsc_pkg::K_SC, 4'd7, 32'h0001_0002, 32'h0, 1, 32'h0, sllsc_pkg::ST_RANGE},
        '{0, 0, sllsc_pkg::K_LL, 4'd3, 32'h0000_0008, 32'h0, 0, 32'h0, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_SW, 4'd0, 32'h0000_0008, 32'h55AA_55AA, 0, 32'h0, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_SC, 4'd3, 32'h0000_0008, 32'h0, 1, 32'h0, sllsc_pkg::ST_SCFAIL},
        '{1, 4'd15, sllsc_pkg::K_LW, 4'd0, 32'h0, 32'h0, 0, 32'h0, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_SC, 4'd9, 32'h0, 32'h0, 1, 32'h0, sllsc_pkg::ST_PROC},
        '{0, 0, sllsc_pkg::K_LL, 4'd7, 32'h0, 32'h0, 0, 32'h0, sllsc_pkg::ST_OK},
        '{1, 4'd0, sllsc_pkg::K_LW, 4'd0, 32'h0, 32'h0, 0, 32'h0, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_SC, 4'd15, 32'h0, 32'h0, 0, 32'h0, sllsc_pkg::ST_OK},
        '{0, 0, sllsc_pkg::K_LW, 4'd0, 32'h0, 32'h0, 0, 32'h0, sllsc_pkg::ST_OK}
    };

    int unsigned phase_procs [N_PHASES] = '{2, 8, 15, 1, 4, 0, 3, 8};

    // DUT connections, all known from time zero
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [sllsc_pkg::NP_W-1:0]      i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [sllsc_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [sllsc_pkg::KIND_W-1:0]    s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [sllsc_pkg::M_TDATA_W-1:0] m_axis_tdata;

    // predictor state
    bit [sllsc_pkg::DATA_W-1:0] mem_model [WORDS];
    bit [sllsc_pkg::DATA_W-1:0] resv_addr [MAXP];
    bit                         resv_valid [MAXP];
    int unsigned                np_model = 1;

    t_reply pending_replies [$];
    t_reply got_reply;
    int     err_count = 0;
    int     accesses = 0;
    int     sc_won = 0;
    int     sc_lost = 0;
    bit     idle_on = 1'b1;
    int     stall_left = 0;

    shared_memory_with_ll_sc_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run (clearing pass included)
    initial begin
        #20_000_000;
        $display("timeout waiting on the DUT");
        $display("simulation failed");
        $finish;
    end

    task automatic flag_error(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // mostly back-to-back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [sllsc_pkg::ST_W-1:0] word_status(
        input logic [sllsc_pkg::DATA_W-1:0] a);
        if (a >= 32'(MEM_SIZE))
            return sllsc_pkg::ST_RANGE;
        if (a[1:0] != 2'b00)
            return sllsc_pkg::ST_ALIGN;
        return sllsc_pkg::ST_OK;
    endfunction

    // predicted reply for one access; updates memory and reservations
    function automatic t_reply model_access(input logic [sllsc_pkg::KIND_W-1:0] kind,
                                            input logic [sllsc_pkg::PID_W-1:0] pid,
                                            input logic [sllsc_pkg::DATA_W-1:0] addr,
                                            input logic [sllsc_pkg::DATA_W-1:0] data);
        t_reply      r;
        int unsigned n_act;
        int unsigned w;
        int          sh;
        bit          shared;
        r.rd   = '0;
        r.st   = sllsc_pkg::ST_OK;
        r.kind = kind;
        r.addr = addr;
        shared = (np_model > 1);
        n_act  = (np_model > MAXP) ? MAXP : np_model;
        w      = addr >> 2;
        sh     = int'(addr[1:0]) * 8;
        case (kind)
            sllsc_pkg::K_LW, sllsc_pkg::K_LL: begin
                // LL reserves before the range/alignment checks
                if (kind == sllsc_pkg::K_LL && shared) begin
                    if (pid >= n_act) begin
                        r.st = sllsc_pkg::ST_PROC;
                        return r;
                    end
                    resv_addr[pid]  = addr;
                    resv_valid[pid] = 1'b1;
                end
                r.st = word_status(addr);
                if (r.st == sllsc_pkg::ST_OK)
                    r.rd = mem_model[w];
            end
            sllsc_pkg::K_SW, sllsc_pkg::K_SC: begin
                if (shared) begin
                    if (kind == sllsc_pkg::K_SC) begin
                        if (pid >= n_act) begin
                            r.st = sllsc_pkg::ST_PROC;
                            return r;
                        end
                        if (!resv_valid[pid] || resv_addr[pid] != addr) begin
                            r.st = sllsc_pkg::ST_SCFAIL;
                            sc_lost++;
                            return r;
                        end
                        sc_won++;
                    end
                    // exact-address match drops every active reservation
                    for (int i = 0; i < n_act; i++)
                        if (resv_valid[i] && resv_addr[i] == addr)
                            resv_valid[i] = 1'b0;
                end
                r.st = word_status(addr);
                if (r.st == sllsc_pkg::ST_OK)
                    mem_model[w] = data;
            end
            sllsc_pkg::K_LB: begin
                if (addr >= 32'(MEM_SIZE))
                    r.st = sllsc_pkg::ST_RANGE;
                else
                    r.rd = (mem_model[w] >> sh) & 32'hFF;
            end
            sllsc_pkg::K_SB: begin
                if (addr >= 32'(MEM_SIZE))
                    r.st = sllsc_pkg::ST_RANGE;
                else
                    mem_model[w] = (mem_model[w] & ~(32'hFF << sh))
                                 | ({24'h0, data[7:0]} << sh);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // one request transfer; tvalid is only lowered when a gap follows
    task automatic issue_access(input logic [sllsc_pkg::KIND_W-1:0] kind,
                                input logic [sllsc_pkg::PID_W-1:0] pid,
                                input logic [sllsc_pkg::DATA_W-1:0] addr,
                                input logic [sllsc_pkg::DATA_W-1:0] data,
                                input bit typed, input t_reply given);
        int     gap;
        t_reply pred;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, data, addr, pid};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = model_access(kind, pid, addr, data);
        if (typed) begin
            pred.rd = given.rd;
            pred.st = given.st;
        end
        pending_replies.push_back(pred);
        if (kind < K_UNUSED_A)
            accesses++;
    endtask

    // quiesce: no request pending and every reply back, plus pipeline slack
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_procs(input int unsigned n);
        drain_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= sllsc_pkg::NP_W'(n);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        np_model = n;
    endtask

    function automatic logic [sllsc_pkg::PID_W-1:0] pick_pid();
        int eff;
        eff = (np_model > MAXP) ? MAXP : int'(np_model);
        if (eff >= 1 && $urandom_range(0, 9) != 0)
            return sllsc_pkg::PID_W'($urandom_range(0, eff - 1));
        return sllsc_pkg::PID_W'($urandom_range(0, 15));
    endfunction

    // small hot pool so reservations collide, plus edges and full-range noise
    function automatic logic [sllsc_pkg::DATA_W-1:0] pick_addr(input bit byte_lane);
        int                           r;
        logic [sllsc_pkg::DATA_W-1:0] a;
        r = $urandom_range(0, 99);
        if (r < 45)
            a = 32'($urandom_range(0, 7)) << 2;
        else if (r < 55)
            a = 32'(MEM_SIZE - 4) - (32'($urandom_range(0, 7)) << 2);
        else if (r < 85)
            a = 32'($urandom_range(0, MEM_SIZE - 1)) & ~32'h3;
        else if (r < 95)
            a = $urandom;
        else
            a = 32'(MEM_SIZE) + 32'($urandom_range(0, 7));
        if (byte_lane || $urandom_range(0, 11) == 0)
            a[1:0] = 2'($urandom_range(0, 3));
        return a;
    endfunction

    task automatic random_access();
        int                           r;
        logic [sllsc_pkg::KIND_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 18)      k = sllsc_pkg::K_LW;
        else if (r < 36) k = sllsc_pkg::K_SW;
        else if (r < 52) k = sllsc_pkg::K_LL;
        else if (r < 66) k = sllsc_pkg::K_SC;
        else if (r < 80) k = sllsc_pkg::K_LB;
        else if (r < 94) k = sllsc_pkg::K_SB;
        else if (r < 97) k = K_UNUSED_A;
        else             k = K_UNUSED_B;
        issue_access(k, pick_pid(), pick_addr(k == sllsc_pkg::K_LB || k == sllsc_pkg::K_SB),
                     $urandom, 1'b0, '0);
    endtask

    // LL, a few interfering accesses, then SC from the same processor
    task automatic linked_sequence();
        logic [sllsc_pkg::PID_W-1:0]  p;
        logic [sllsc_pkg::DATA_W-1:0] a;
        int                           extra;
        p     = pick_pid();
        a     = pick_addr(1'b0);
        extra = $urandom_range(0, 3);
        issue_access(sllsc_pkg::K_LL, p, a, $urandom, 1'b0, '0);
        repeat (extra) random_access();
        issue_access(sllsc_pkg::K_SC, p, a, $urandom, 1'b0, '0);
    endtask

    // result receiver with random back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= pick_gap();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                flag_error($sformatf("result %h with nothing outstanding", m_axis_tdata));
            end else begin
                got_reply = pending_replies.pop_front();
                if (m_axis_tdata[31:0] !== got_reply.rd)
                    flag_error($sformatf("kind %0d addr %h: read_data %h, want %h",
                        got_reply.kind, got_reply.addr, m_axis_tdata[31:0], got_reply.rd));
                if (m_axis_tdata[34:32] !== got_reply.st)
                    flag_error($sformatf("kind %0d addr %h: status %0d, want %0d",
                        got_reply.kind, got_reply.addr, m_axis_tdata[34:32], got_reply.st));
            end
        end
    end

    // main sequence
    initial begin
        t_reply given;
        int     start;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (script[i]) begin
            if (script[i].cfg) begin
                set_procs(script[i].np);
            end else begin
                given    = '0;
                given.rd = script[i].rd;
                given.st = script[i].st;
                issue_access(script[i].kind, script[i].pid, script[i].addr, script[i].data,
                             script[i].typed, given);
            end
        end

        // random phases, one num_procs setting each; some phases without idling
        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_procs(phase_procs[ph]);
            idle_on = (ph % 3 != 2);
            start   = accesses;
            while (accesses - start < PHASE_ITEMS) begin
                if ($urandom_range(0, 1) == 0)
                    linked_sequence();
                else
                    random_access();
            end
        end

        idle_on = 1'b0;
        drain_block();
        $display("Ran %0d accesses across %0d processor-count settings.",
                 accesses, N_PHASES + 3);
        $display("Store-conditionals: %0d won, %0d lost; %0d mismatches.",
                 sc_won, sc_lost, err_count);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
